>>> hw/rtl/ifre_pkg.sv
package ifre_pkg;

  // Default sizing of the frame store
  localparam int MAX_DIM_DEF     = 64;
  localparam int STORE_DEPTH_DEF = 4096;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Field widths
  localparam int PIXEL_W     = 8;
  localparam int COORD_W     = 6;
  localparam int MODE_W      = 3;
  localparam int DIM_REG_W   = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

  // View modes; codes above MODE_ROT_RIGHT act as identity
  localparam logic [MODE_W-1:0] MODE_IDENT       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MIRROR_COLS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIRROR_ROWS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT_LEFT    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROT_RIGHT   = 3'd4;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Register reset values
  localparam logic [MODE_W-1:0]    MODE_RST = MODE_IDENT;
  localparam logic [DIM_REG_W-1:0] DIM_RST  = 7'd64;

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_last;
    logic               ready_res;
  } out_item_t;

  // Classified operation handed from front to back
  typedef struct packed {
    logic               is_load;
    logic               ready_res;
    logic               addr_ok;
    logic               frame_last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIXEL_W-1:0] pixel;
  } op_t;

endpackage

>>> hw/rtl/ifre_front.sv
module ifre_front import ifre_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  in_item_t                       item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  output logic                           push_valid,
  input  logic                           push_ready,
  output op_t                            push_op,
  output logic [$clog2(STORE_DEPTH)-1:0] push_addr
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int RW = $clog2(MAX_DIM);
  localparam int EW = ($clog2(MAX_DIM + 1) > DIM_REG_W) ? $clog2(MAX_DIM + 1) : DIM_REG_W;
  localparam int IW = $clog2(MAX_DIM * MAX_DIM);

  logic [MODE_W-1:0]    mode, mode_next;
  logic [DIM_REG_W-1:0] frame_width, frame_width_next;
  logic [DIM_REG_W-1:0] frame_height, frame_height_next;
  logic [RW-1:0]        load_row, load_row_next, load_col, load_col_next;
  logic [RW-1:0]        emit_row, emit_row_next, emit_col, emit_col_next;
  logic                 frame_full, frame_full_next;

  logic [EW-1:0] w_eff, h_eff, out_rows, out_cols;
  logic [EW-1:0] w_ext, h_ext;
  logic          rot;
  logic [RW-1:0] lr, lc, ei, ej, sr, sc, row_sel, col_sel;
  logic [EW-1:0] w_minus_j, h_minus_i, w_minus_i, h_minus_j;
  logic [IW-1:0] idx;
  logic          accept, emit_last;

  assign w_ext = EW'(frame_width);
  assign h_ext = EW'(frame_height);

  // Clamp dimensions to 1..MAX_DIM
  always_comb begin
    if (frame_width == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end else begin
      w_eff = w_ext;
    end
    if (frame_height == '0) begin
      h_eff = EW'(1);
    end else if (h_ext > EW'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end else begin
      h_eff = h_ext;
    end
  end

  assign rot      = (mode == MODE_ROT_LEFT) || (mode == MODE_ROT_RIGHT);
  assign out_rows = rot ? w_eff : h_eff;
  assign out_cols = rot ? h_eff : w_eff;

  // Restart positions that fell outside the current frame
  always_comb begin
    if (EW'(load_row) >= h_eff || EW'(load_col) >= w_eff) begin
      lr = '0;
      lc = '0;
    end else begin
      lr = load_row;
      lc = load_col;
    end
    if (EW'(emit_row) >= out_rows || EW'(emit_col) >= out_cols) begin
      ei = '0;
      ej = '0;
    end else begin
      ei = emit_row;
      ej = emit_col;
    end
  end

  assign w_minus_j = w_eff - EW'(1) - EW'(ej);
  assign h_minus_i = h_eff - EW'(1) - EW'(ei);
  assign w_minus_i = w_eff - EW'(1) - EW'(ei);
  assign h_minus_j = h_eff - EW'(1) - EW'(ej);

  // Source coordinate of the output pixel
  always_comb begin
    case (mode)
      MODE_MIRROR_COLS: begin
        sr = ei;
        sc = RW'(w_minus_j);
      end
      MODE_MIRROR_ROWS: begin
        sr = RW'(h_minus_i);
        sc = ej;
      end
      MODE_ROT_LEFT: begin
        sr = ej;
        sc = RW'(w_minus_i);
      end
      MODE_ROT_RIGHT: begin
        sr = RW'(h_minus_j);
        sc = ei;
      end
      default: begin
        sr = ei;
        sc = ej;
      end
    endcase
  end

  assign emit_last = (EW'(ei) + EW'(1) == out_rows) && (EW'(ej) + EW'(1) == out_cols);

  // One address unit shared by loads and reads
  assign row_sel   = (item.kind == KIND_LOAD) ? lr : sr;
  assign col_sel   = (item.kind == KIND_LOAD) ? lc : sc;
  assign idx       = IW'(row_sel) * IW'(MAX_DIM) + IW'(col_sel);
  assign push_addr = AW'(idx);

  assign accept     = item_valid && push_ready;
  assign item_ready = push_ready;
  assign push_valid = item_valid;
  assign cfg_ready  = 1'b1;

  always_comb begin
    push_op            = '0;
    push_op.is_load    = (item.kind == KIND_LOAD);
    push_op.pixel      = item.pixel_in;
    if (item.kind == KIND_LOAD) begin
      push_op.addr_ok = (32'(idx) < 32'(STORE_DEPTH));
    end else if (frame_full) begin
      push_op.ready_res  = 1'b1;
      push_op.addr_ok    = (32'(idx) < 32'(STORE_DEPTH));
      push_op.frame_last = emit_last;
      push_op.row        = COORD_W'(ei);
      push_op.col        = COORD_W'(ej);
    end
  end

  always_comb begin
    mode_next         = mode;
    frame_width_next  = frame_width;
    frame_height_next = frame_height;
    load_row_next     = load_row;
    load_col_next     = load_col;
    emit_row_next     = emit_row;
    emit_col_next     = emit_col;
    frame_full_next   = frame_full;

    if (accept) begin
      if (item.kind == KIND_LOAD) begin
        frame_full_next = 1'b0;
        if (EW'(lc) + EW'(1) < w_eff) begin
          load_row_next = lr;
          load_col_next = lc + RW'(1);
        end else begin
          load_col_next = '0;
          if (EW'(lr) + EW'(1) < h_eff) begin
            load_row_next = lr + RW'(1);
          end else begin
            load_row_next   = '0;
            frame_full_next = 1'b1;
            emit_row_next   = '0;
            emit_col_next   = '0;
          end
        end
      end else if (frame_full) begin
        if (EW'(ej) + EW'(1) < out_cols) begin
          emit_row_next = ei;
          emit_col_next = ej + RW'(1);
        end else begin
          emit_col_next = '0;
          emit_row_next = (EW'(ei) + EW'(1) < out_rows) ? ei + RW'(1) : '0;
        end
      end
    end

    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: begin
          mode_next     = cfg_data[MODE_W-1:0];
          emit_row_next = '0;
          emit_col_next = '0;
        end
        REG_WIDTH, REG_HEIGHT: begin
          if (cfg_index == REG_WIDTH) begin
            frame_width_next = cfg_data;
          end else begin
            frame_height_next = cfg_data;
          end
          load_row_next   = '0;
          load_col_next   = '0;
          emit_row_next   = '0;
          emit_col_next   = '0;
          frame_full_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_RST;
      frame_width  <= DIM_RST;
      frame_height <= DIM_RST;
      load_row     <= '0;
      load_col     <= '0;
      emit_row     <= '0;
      emit_col     <= '0;
      frame_full   <= 1'b0;
    end else begin
      mode         <= mode_next;
      frame_width  <= frame_width_next;
      frame_height <= frame_height_next;
      load_row     <= load_row_next;
      load_col     <= load_col_next;
      emit_row     <= emit_row_next;
      emit_col     <= emit_col_next;
      frame_full   <= frame_full_next;
    end
  end

endmodule

>>> hw/rtl/ifre_queue.sv
module ifre_queue import ifre_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/ifre_back.sv
module ifre_back import ifre_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           op_valid,
  output logic                           op_pop,
  input  op_t                            op,
  input  logic [$clog2(STORE_DEPTH)-1:0] op_addr,
  output logic                           result_valid,
  input  logic                           result_ready,
  output out_item_t                      result
);

  logic [PIXEL_W-1:0] frame_store [STORE_DEPTH];
  logic [PIXEL_W-1:0] rd_data;
  op_t                held_op;
  logic               out_free;

  // Loads never touch the output register, so they drain even while it stalls
  assign out_free = !result_valid || result_ready;
  assign op_pop   = op_valid && (op.is_load || out_free);

  always_ff @(posedge clk) begin
    if (op_pop && op.is_load && op.addr_ok) begin
      frame_store[op_addr] <= op.pixel;
    end
    if (op_pop && !op.is_load && op.addr_ok) begin
      rd_data <= frame_store[op_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && !op.is_load) begin
      held_op <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (op_pop && !op.is_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    result            = '0;
    result.pixel_out  = (held_op.ready_res && held_op.addr_ok) ? rd_data : '0;
    result.out_row    = held_op.row;
    result.out_col    = held_op.col;
    result.frame_last = held_op.frame_last;
    result.ready_res  = held_op.ready_res;
  end

endmodule

>>> hw/rtl/image_flip_rotate_engine.sv
// An accepted item is written into the op queue at its accept edge; a read popped
//   from the queue reads the frame store into the registered result.
// Throughput: one item per cycle while the op queue has room; set by the single port of the frame store.
// Loads cause no result and drain from the queue even while the result is stalled.
// Reset (rst, synchronous): clears mode, dims (64 x 64), load and emit positions,
//   the frame-full flag, the queue and the result valid; the frame store is not cleared.
module image_flip_rotate_engine import ifre_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  in_item_t               item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output out_item_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int QW = AW + $bits(op_t);

  // Front to queue
  logic          push_valid, push_ready;
  op_t           push_op;
  logic [AW-1:0] push_addr;

  // Queue to back
  logic          q_valid, q_pop;
  logic [QW-1:0] q_data;
  op_t           q_op;
  logic [AW-1:0] q_addr;

  // Front: holds the registers and the load/emit positions, classifies each transfer
  // as a store write or a store read and computes the store address.
  ifre_front #(
    .MAX_DIM    (MAX_DIM),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_op   (push_op),
    .push_addr (push_addr)
  );

  // Short queue: lets the front keep taking items while the result side stalls.
  ifre_queue #(
    .DATA_W(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_addr, push_op}),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  assign q_addr = q_data[QW-1 -: AW];
  assign q_op   = q_data[$bits(op_t)-1:0];

  // Back: owns the frame store; writes loads, reads into the result register.
  ifre_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (q_valid),
    .op_pop      (q_pop),
    .op          (q_op),
    .op_addr     (q_addr),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // The result register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A full queue must present an op to the back.
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> q_valid)
    else $error("front stalled with an empty queue");

  // A read taken before the frame is loaded carries no pixel, no frame end and zero coordinates.
  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.ready_res) |->
      (result.pixel_out == '0 && !result.frame_last &&
       result.out_row == '0 && result.out_col == '0))
    else $error("non-ready result carries data");

  // A stalled result keeps its payload even while loads drain behind it.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

>>> tb/image_flip_rotate_engine_tb.sv
`timescale 1ns / 1ps

module image_flip_rotate_engine_tb;
  import ifre_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int SETTLE_CYCLES = 8;    // result register plus op queue, with margin
  localparam int HOLD_OFF_CYCLES = 90;

  // Predicts the output view of the frame store and keeps the results still owed.
  class view_model;
    logic [PIXEL_W-1:0]   frame_mem [STORE_DEPTH_DEF];
    logic [MODE_W-1:0]    view_mode;
    logic [DIM_REG_W-1:0] width_reg;
    logic [DIM_REG_W-1:0] height_reg;
    int unsigned          load_r, load_c, emit_r, emit_c;
    bit                   frame_full;
    out_item_t            pixels_due [$];
    int unsigned          n_loads = 0;
    int unsigned          n_reads = 0;
    int unsigned          n_full_reads = 0;
    int unsigned          n_frame_ends = 0;
    int unsigned          n_reg_writes = 0;
    int unsigned          n_errors = 0;

    function new();
      view_mode  = MODE_RST;
      width_reg  = DIM_RST;
      height_reg = DIM_RST;
      restart();
    endfunction

    function void restart();
      load_r = 0;
      load_c = 0;
      emit_r = 0;
      emit_c = 0;
      frame_full = 1'b0;
    endfunction

    // Zero acts as one, anything past the store side acts as the maximum.
    function int unsigned eff_dim(logic [DIM_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_reg_writes++;
      case (idx)
        REG_MODE: begin
          view_mode = data[MODE_W-1:0];
          emit_r = 0;
          emit_c = 0;
        end
        REG_WIDTH: begin
          width_reg = data;
          restart();
        end
        REG_HEIGHT: begin
          height_reg = data;
          restart();
        end
        default: ;
      endcase
    endfunction

    function void take_item(in_item_t it);
      int unsigned w, h, orows, ocols, i, j, sr, sc;
      bit rot;
      out_item_t want;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      if (it.kind == KIND_LOAD) begin
        n_loads++;
        frame_full = 1'b0;
        if (load_r >= h || load_c >= w) begin
          load_r = 0;
          load_c = 0;
        end
        frame_mem[load_r * MAX_DIM_DEF + load_c] = it.pixel_in;
        if (load_c + 1 < w) begin
          load_c++;
        end else begin
          load_c = 0;
          if (load_r + 1 < h) begin
            load_r++;
          end else begin
            load_r = 0;
            frame_full = 1'b1;
            emit_r = 0;
            emit_c = 0;
          end
        end
        return;
      end
      n_reads++;
      want = '0;
      if (frame_full) begin
        n_full_reads++;
        rot = (view_mode == MODE_ROT_LEFT || view_mode == MODE_ROT_RIGHT);
        orows = rot ? w : h;
        ocols = rot ? h : w;
        if (emit_r >= orows || emit_c >= ocols) begin
          emit_r = 0;
          emit_c = 0;
        end
        i = emit_r;
        j = emit_c;
        case (view_mode)
          MODE_MIRROR_COLS: begin sr = i;         sc = w - 1 - j; end
          MODE_MIRROR_ROWS: begin sr = h - 1 - i; sc = j;         end
          MODE_ROT_LEFT:    begin sr = j;         sc = w - 1 - i; end
          MODE_ROT_RIGHT:   begin sr = h - 1 - j; sc = i;         end
          default:          begin sr = i;         sc = j;         end
        endcase
        want.pixel_out  = frame_mem[sr * MAX_DIM_DEF + sc];
        want.out_row    = COORD_W'(i);
        want.out_col    = COORD_W'(j);
        want.frame_last = (i + 1 == orows) && (j + 1 == ocols);
        want.ready_res  = 1'b1;
        if (j + 1 < ocols) begin
          emit_c++;
        end else begin
          emit_c = 0;
          emit_r = (i + 1 < orows) ? i + 1 : 0;
        end
      end
      pixels_due.push_back(want);
    endfunction

    function void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
        n_errors++;
      end
    endfunction

    function void check_view_pixel(out_item_t got);
      out_item_t want;
      if (pixels_due.size() == 0) begin
        $error("result with no read request outstanding: %h", got);
        n_errors++;
        return;
      end
      want = pixels_due.pop_front();
      if (want.frame_last) n_frame_ends++;
      check_field("pixel_out",  want.pixel_out,      got.pixel_out);
      check_field("out_row",    8'(want.out_row),    8'(got.out_row));
      check_field("out_col",    8'(want.out_col),    8'(got.out_col));
      check_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
      check_field("ready_res",  8'(want.ready_res),  8'(got.ready_res));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  in_item_t               item;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  out_item_t              result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  view_model   sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned n_sent = 0;

  image_flip_rotate_engine dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering items meanwhile.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        result_ready = 1'b0;
        hold_left--;
      end else begin
        result_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every result transfer against the oldest outstanding read.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_view_pixel(result);
  end

  // Offer one item after a random gap; hold it until the transfer, then drop valid.
  // Entered and left at a falling edge.
  task automatic send_item(input logic k, input logic [PIXEL_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item.kind = k;
    item.pixel_in = pix;
    do @(posedge clk); while (!item_ready);
    sb.take_item(item);
    n_sent++;
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  // Wait until every read has been answered, then let loads drain from the queue.
  task automatic drain_results();
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes only go out with the block idle.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Load a frame in raster order, with the odd early read mixed in as noise.
  task automatic load_frame(input int unsigned n_pix, input int unsigned noise_pct);
    for (int unsigned k = 0; k < n_pix; k++) begin
      if ($urandom_range(99) < noise_pct) send_item(KIND_READ, PIXEL_W'($urandom));
      send_item(KIND_LOAD, PIXEL_W'($urandom));
    end
  endtask

  task automatic read_pixels(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_item(KIND_READ, PIXEL_W'($urandom));
  endtask

  // Mostly small dimensions; zero and oversize codes show up too. A wide
  // frame is kept short so frame sizes stay modest.
  function automatic logic [DIM_REG_W-1:0] pick_dim(input bit narrow);
    int unsigned p;
    p = $urandom_range(99);
    if (narrow) return DIM_REG_W'($urandom_range(4));
    if (p < 70) return DIM_REG_W'($urandom_range(8, 1));
    if (p < 78) return '0;
    if (p < 90) return DIM_REG_W'($urandom_range(127, 64));
    return DIM_REG_W'($urandom_range(63, 9));
  endfunction

  task automatic write_dims();
    logic [DIM_REG_W-1:0] w_code, h_code;
    w_code = pick_dim(1'b0);
    h_code = pick_dim(sb.eff_dim(w_code) > 4);
    if ($urandom_range(1)) begin
      cfg_write(REG_WIDTH, w_code);
      cfg_write(REG_HEIGHT, h_code);
    end else begin
      cfg_write(REG_HEIGHT, h_code);
      cfg_write(REG_WIDTH, w_code);
    end
  endtask

  // Mostly the five views, sometimes an alias code; upper data bits are noise.
  task automatic write_mode();
    logic [MODE_W-1:0] m;
    if ($urandom_range(9) < 9) m = MODE_W'($urandom_range(MODE_ROT_RIGHT));
    else m = MODE_W'($urandom_range(7, MODE_ROT_RIGHT + 1));
    cfg_write(REG_MODE, {4'($urandom), m});
  endtask

  function automatic int unsigned frame_pixels();
    return sb.eff_dim(sb.width_reg) * sb.eff_dim(sb.height_reg);
  endfunction

  function automatic int unsigned read_count();
    int unsigned cap;
    cap = 2 * frame_pixels() + 2;
    if (cap > 160) cap = 160;
    return $urandom_range(cap, 1);
  endfunction

  // One random phase: mostly a full load followed by reads, sometimes a new
  // view of the frame already held, a reload, or a broken mix of both kinds.
  task automatic run_segment();
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(7) == 0) cfg_write(CFG_INDEX_W'(3), CFG_DATA_W'($urandom));
    if (pick < 60) begin
      write_dims();
      write_mode();
      load_frame(frame_pixels(), 4);
      read_pixels(read_count());
    end else if (pick < 75) begin
      write_mode();
      read_pixels(read_count());
    end else if (pick < 85) begin
      load_frame(frame_pixels(), 4);
      read_pixels(read_count());
    end else begin
      if ($urandom_range(1)) write_dims();
      repeat ($urandom_range(40, 1)) begin
        if ($urandom_range(99) < 55) send_item(KIND_LOAD, PIXEL_W'($urandom));
        else send_item(KIND_READ, PIXEL_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned random_start, done;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: a read before any frame is loaded answers not-ready.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(KIND_READ, 8'hFF);
    // Two-pixel frame with extreme pixel values, then each view read three
    // times so the last pixel and the wrap to the frame start both show.
    cfg_write(REG_WIDTH, 7'd2);
    cfg_write(REG_HEIGHT, 7'd1);
    send_item(KIND_LOAD, 8'h00);
    send_item(KIND_LOAD, 8'hFF);
    cfg_write(REG_MODE, {4'd0, MODE_IDENT});
    read_pixels(3);
    cfg_write(REG_MODE, {4'd0, MODE_MIRROR_COLS});
    read_pixels(3);
    cfg_write(REG_MODE, {4'd0, MODE_MIRROR_ROWS});
    read_pixels(3);
    cfg_write(REG_MODE, {4'd0, MODE_ROT_LEFT});
    read_pixels(3);
    cfg_write(REG_MODE, {4'd0, MODE_ROT_RIGHT});
    read_pixels(3);
    // A load after a complete frame starts a new one; reads go not-ready again.
    send_item(KIND_LOAD, 8'h5A);
    send_item(KIND_READ, 8'h00);

    random_start = n_sent;
    send_idle_pct = 35;
    recv_idle_pct = 51;

    // Hold off the result side while reads keep coming so the queue fills
    // and the input side has to stall.
    cfg_write(REG_WIDTH, 7'd4);
    cfg_write(REG_HEIGHT, 7'd4);
    cfg_write(REG_MODE, {4'd0, MODE_ROT_LEFT});
    load_frame(16, 0);
    hold_req = 1'b1;
    read_pixels(40);

    // Random phases under three idling regimes.
    done = n_sent - random_start;
    while (done < RANDOM_ITEMS) begin
      if (done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 51;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_segment();
      done = n_sent - random_start;
    end

    // A full-width frame two rows tall: the top row index shows in the
    // rotated view and the top column index in the mirrored one, each read
    // a bit past its end.
    cfg_write(REG_WIDTH, 7'd64);
    cfg_write(REG_HEIGHT, 7'd2);
    cfg_write(REG_MODE, {4'b1010, MODE_ROT_RIGHT});
    load_frame(2 * MAX_DIM_DEF, 0);
    read_pixels(2 * MAX_DIM_DEF + 3);
    cfg_write(REG_MODE, {4'b0101, MODE_MIRROR_ROWS});
    read_pixels(2 * MAX_DIM_DEF + 3);

    drain_results();
    $display("Covered %0d loads and %0d reads (%0d on a full frame, %0d frame ends)",
             sb.n_loads, sb.n_reads, sb.n_full_reads, sb.n_frame_ends);
    $display("with %0d register writes across all views, aliases, clamped sizes and stalls",
             sb.n_reg_writes);
    if (sb.n_errors == 0) begin
      $display("image_flip_rotate_engine test passed");
    end else begin
      $display("image_flip_rotate_engine test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $error("timeout with %0d results outstanding", sb.pixels_due.size());
    $display("image_flip_rotate_engine test failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ifre_pkg.sv
hw/rtl/ifre_front.sv
hw/rtl/ifre_queue.sv
hw/rtl/ifre_back.sv
hw/rtl/image_flip_rotate_engine.sv
tb/image_flip_rotate_engine_tb.sv
